@@ hw/rtl/srt_pkg.sv @@
package srt_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int MAX_RESULTS   = 16;
  localparam logic [19:0] MIN_RUN_RESET = 20'd7000;
  localparam logic [15:0] AGE_RESET     = 16'd100;

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_TICK      = 2'd1,
    REQ_FLUSH_OLD = 2'd2,
    REQ_FLUSH_ALL = 2'd3
  } req_t;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_EMIT   = 1'b1
  } kind_t;

  typedef enum logic {
    REG_MIN_RUN = 1'b0,
    REG_AGE     = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_WR,
    ST_REPORT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EM_RD,
    ST_EM_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] len;
    logic [7:0]  tag;
    logic [31:0] stamp;
  } entry_t;

endpackage

@@ hw/rtl/srt_mem.sv @@
module srt_mem
  import srt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, data holds while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/segment_reorder_table.sv @@
// Reorder table for up to TABLE_DEPTH segments kept sorted by unsigned sequence
// number in one single-port-read memory organized as a ring (head pointer plus
// fill count). One transaction is taken at a time. An insert walks W entries
// from the head and moves S entries up to open the slot; a flush of old entries
// scans every entry for age and then emits segments, a flush of all emits
// directly (at most 16 segments per request). Every memory access takes a read
// state and a use state. A full table drops the insert and reports it; results
// wait in one output register.
module segment_reorder_table
  import srt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_seg_seq,
  input  logic [15:0] in_seg_len,
  input  logic [7:0]  in_seg_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic        out_pivot_found,
  output logic [31:0] out_pivot_seq,
  output logic        out_insert_dropped,
  output logic [31:0] out_seq,
  output logic [15:0] out_len,
  output logic [7:0]  out_handle,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = 16 + IW;

  state_t state_r, state_nxt;

  logic [19:0]   min_run_r;
  logic [15:0]   age_limit_r;
  logic [CW-1:0] count_r;
  logic [IW-1:0] head_r;
  logic [31:0]   tick_r;

  logic [31:0]   req_seq_r;
  logic [15:0]   req_len_r;
  logic [7:0]    req_tag_r;
  logic          drop_r;

  logic [CW-1:0] idx_r;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] ins_r;
  logic [CW-1:0] j_r;
  logic [31:0]   cur_seq_r;
  logic [15:0]   cur_len_r;
  logic [RW-1:0] run_r;
  logic          found_r;
  logic [31:0]   piv_seq_r;
  logic          have_r;
  logic [CW-1:0] piv_r;
  logic [CW-1:0] upto_r;
  logic [CW-1:0] emit_n_r;

  logic          out_valid_r;
  logic          kind_r;
  logic          pf_r;
  logic [31:0]   ps_r;
  logic          dr_r;
  logic [31:0]   os_r;
  logic [15:0]   ol_r;
  logic [7:0]    oh_r;
  logic          last_r;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  logic          slot_free;
  logic          accept;

  // map a logical index onto the ring
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(i);
    if (s >= (CW+1)'(TABLE_DEPTH)) begin
      s = s - (CW+1)'(TABLE_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  srt_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  // walk step decisions
  logic          is_head;
  logic          step;
  logic          walk_more;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] new_pos;
  logic [31:0]   new_cur_seq;
  logic [CW-1:0] walk_ins;
  logic [RW-1:0] run_step;
  logic          contig;

  always_comb begin
    idx_inc     = CW'(idx_r + 1'b1);
    is_head     = (idx_r == '0);
    step        = !is_head && (mem_rdata.seq < req_seq_r);
    contig      = ((cur_seq_r + 32'(cur_len_r)) == mem_rdata.seq);
    run_step    = contig ? RW'(run_r + RW'(mem_rdata.len)) : RW'(mem_rdata.len);
    new_pos     = step ? idx_r : (is_head ? '0 : pos_r);
    new_cur_seq = (is_head || step) ? mem_rdata.seq : cur_seq_r;
    walk_more   = (is_head || step) && (idx_inc < count_r);
    walk_ins    = (new_cur_seq > req_seq_r) ? new_pos : CW'(new_pos + 1'b1);
  end

  // age test for the scan
  logic          is_old;
  logic [CW-1:0] n_emit;
  assign is_old = ((tick_r - mem_rdata.stamp) >= 32'(age_limit_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req_t'(in_req_type))
            REQ_INSERT: begin
              if (count_r >= CW'(TABLE_DEPTH)) begin
                state_nxt = ST_REPORT;
              end else if (count_r == '0) begin
                state_nxt = ST_INS_WR;
              end else begin
                state_nxt = ST_WALK_RD;
              end
            end
            REQ_TICK:      state_nxt = ST_IDLE;
            REQ_FLUSH_OLD: state_nxt = (count_r == '0) ? ST_IDLE : ST_SCAN_RD;
            REQ_FLUSH_ALL: state_nxt = (count_r == '0) ? ST_IDLE : ST_EM_RD;
            default:       state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WALK_RD:  state_nxt = ST_WALK_CHK;
      ST_WALK_CHK: begin
        if (walk_more) begin
          state_nxt = ST_WALK_RD;
        end else if (count_r > walk_ins) begin
          state_nxt = ST_SH_RD;
        end else begin
          state_nxt = ST_INS_WR;
        end
      end
      ST_SH_RD: state_nxt = ST_SH_WR;
      ST_SH_WR: state_nxt = (CW'(j_r - 1'b1) > ins_r) ? ST_SH_RD : ST_INS_WR;
      ST_INS_WR: state_nxt = ST_REPORT;
      ST_REPORT: state_nxt = slot_free ? ST_IDLE : ST_REPORT;
      ST_SCAN_RD: state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (idx_inc < count_r) begin
          state_nxt = ST_SCAN_RD;
        end else if (is_old ? (idx_r != '0) : (have_r && piv_r != '0)) begin
          state_nxt = ST_EM_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EM_RD: state_nxt = ST_EM_OUT;
      ST_EM_OUT: begin
        if (slot_free) begin
          state_nxt = (idx_inc == emit_n_r) ? ST_IDLE : ST_EM_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory controls and handshake
  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = phys(head_r, idx_r);
    mem_we    = 1'b0;
    mem_waddr = phys(head_r, ins_r);
    mem_wdata = '{seq: req_seq_r, len: req_len_r, tag: req_tag_r, stamp: tick_r};
    case (state_r)
      ST_IDLE:    in_ready = 1'b1;
      ST_WALK_RD,
      ST_SCAN_RD,
      ST_EM_RD:   mem_re = 1'b1;
      ST_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = phys(head_r, CW'(j_r - 1'b1));
      end
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = phys(head_r, j_r);
        mem_wdata = mem_rdata;
      end
      ST_INS_WR:  mem_we = 1'b1;
      default: begin
      end
    endcase
  end

  // limit a flush to the per-request result budget
  function automatic logic [CW-1:0] clip(input logic [CW-1:0] u);
    return (32'(u) > 32'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : u;
  endfunction

  assign n_emit = clip(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_run_r   <= MIN_RUN_RESET;
      age_limit_r <= AGE_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MIN_RUN: min_run_r   <= cfg_wdata;
        REG_AGE:     age_limit_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // table bookkeeping and time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      tick_r  <= '0;
    end else begin
      if (accept && req_t'(in_req_type) == REQ_TICK) begin
        tick_r <= tick_r + 32'd1;
      end
      if (state_r == ST_INS_WR) begin
        count_r <= CW'(count_r + 1'b1);
      end
      if (state_r == ST_EM_OUT && slot_free && idx_inc == emit_n_r) begin
        count_r <= CW'(count_r - emit_n_r);
        head_r  <= phys(head_r, emit_n_r);
      end
    end
  end

  // transaction datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        req_seq_r <= in_seg_seq;
        req_len_r <= in_seg_len;
        req_tag_r <= in_seg_handle;
        drop_r    <= (count_r >= CW'(TABLE_DEPTH));
        idx_r     <= '0;
        ins_r     <= '0;
        found_r   <= 1'b0;
        piv_seq_r <= '0;
        have_r    <= 1'b0;
        piv_r     <= '0;
        upto_r    <= count_r;
        emit_n_r  <= clip(count_r);
      end
      ST_WALK_CHK: begin
        if (is_head) begin
          run_r <= RW'(mem_rdata.len);
        end else if (step) begin
          run_r <= run_step;
          if (32'(run_step) >= 32'(min_run_r)) begin
            found_r   <= 1'b1;
            piv_seq_r <= mem_rdata.seq;
          end
        end
        if (is_head || step) begin
          cur_seq_r <= mem_rdata.seq;
          cur_len_r <= mem_rdata.len;
        end
        pos_r <= new_pos;
        idx_r <= idx_inc;
        ins_r <= walk_ins;
        j_r   <= count_r;
      end
      ST_SH_WR: j_r <= CW'(j_r - 1'b1);
      ST_SCAN_CHK: begin
        if (is_old) begin
          have_r <= 1'b1;
          piv_r  <= idx_r;
        end
        if (idx_inc < count_r) begin
          idx_r <= idx_inc;
        end else begin
          idx_r    <= '0;
          upto_r   <= is_old ? idx_r : piv_r;
          emit_n_r <= is_old ? n_emit : clip(piv_r);
        end
      end
      ST_EM_OUT: begin
        if (slot_free) begin
          idx_r <= idx_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_REPORT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (state_r == ST_EM_OUT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_REPORT && slot_free) begin
      kind_r <= KIND_REPORT;
      pf_r   <= found_r && !drop_r;
      ps_r   <= drop_r ? '0 : piv_seq_r;
      dr_r   <= drop_r;
      os_r   <= '0;
      ol_r   <= '0;
      oh_r   <= '0;
      last_r <= 1'b0;
    end else if (state_r == ST_EM_OUT && slot_free) begin
      kind_r <= KIND_EMIT;
      pf_r   <= 1'b0;
      ps_r   <= '0;
      dr_r   <= 1'b0;
      os_r   <= mem_rdata.seq;
      ol_r   <= mem_rdata.len;
      oh_r   <= mem_rdata.tag;
      last_r <= (idx_inc == upto_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = kind_r;
  assign out_pivot_found    = pf_r;
  assign out_pivot_seq      = ps_r;
  assign out_insert_dropped = dr_r;
  assign out_seq            = os_r;
  assign out_len            = ol_r;
  assign out_handle         = oh_r;
  assign out_last_of_run    = last_r;

  // fill count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // a drop report only comes from a full table
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPORT && drop_r) |-> (count_r == CW'(TABLE_DEPTH)))
    else $error("drop reported with room in table");

  // no memory write outside a running insert
  a_idle_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  // closing a flush batch removes exactly the emitted entries
  a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EM_OUT && slot_free && idx_inc == emit_n_r) |=>
      (count_r == CW'($past(count_r) - $past(emit_n_r))))
    else $error("fill count wrong after flush");

endmodule
